/* hw/rtl/lqmm_pkg.sv */
// ----------------------------------------------------------------------------
// lqmm_pkg
// Shared widths, request and status codes, and types for the linear queue
// with min/max scan.
// ----------------------------------------------------------------------------
package lqmm_pkg;

  localparam int DATA_W        = 32;
  localparam int REQ_W         = 2;
  localparam int STATUS_W      = 2;
  localparam int CAP_W         = 7;
  localparam int DEFAULT_DEPTH = 64;

  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  typedef enum logic [REQ_W-1:0] {
    REQ_ENQ    = 2'd0,
    REQ_DEQ    = 2'd1,
    REQ_MINMAX = 2'd2,
    REQ_NONE   = 2'd3
  } req_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_EMPTY     = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DEQ,
    S_SCAN
  } state_t;

  // Memory port strobes issued by the controller.
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctl_t;

endpackage

/* hw/rtl/lqmm_mem.sv */
// ----------------------------------------------------------------------------
// lqmm_mem
// Slot storage: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lqmm_mem #(
  parameter int DEPTH = lqmm_pkg::DEFAULT_DEPTH,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                               clk,
  input  lqmm_pkg::mem_ctl_t                 ctl,
  input  logic [AW-1:0]                      wr_addr,
  input  logic signed [lqmm_pkg::DATA_W-1:0] wr_data,
  input  logic [AW-1:0]                      rd_addr,
  output logic signed [lqmm_pkg::DATA_W-1:0] rd_data
);
  import lqmm_pkg::*;

  logic signed [DATA_W-1:0] mem [DEPTH];
  logic signed [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* hw/rtl/lqmm_ctrl.sv */
// ----------------------------------------------------------------------------
// lqmm_ctrl
// Request sequencer: queue counters, capacity register, memory port control
// and the min/max scan over the unread slots.
// ----------------------------------------------------------------------------
module lqmm_ctrl #(
  parameter int DEPTH = lqmm_pkg::DEFAULT_DEPTH,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [lqmm_pkg::REQ_W-1:0]           in_req_type,
  input  logic                                 cfg_we,
  input  logic [lqmm_pkg::CAP_W-1:0]           cfg_wdata,
  output lqmm_pkg::mem_ctl_t                   mem_ctl,
  output logic [AW-1:0]                        mem_wr_addr,
  output logic [AW-1:0]                        mem_rd_addr,
  input  logic signed [lqmm_pkg::DATA_W-1:0]   mem_rd_data,
  output logic                                 out_valid,
  output logic [lqmm_pkg::STATUS_W-1:0]        out_status,
  output logic signed [lqmm_pkg::DATA_W-1:0]   out_data,
  output logic signed [lqmm_pkg::DATA_W-1:0]   out_min_value,
  output logic signed [lqmm_pkg::DATA_W-1:0]   out_max_value
);
  import lqmm_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int UW = (CW > CAP_W) ? CW : CAP_W;

  state_t                   state_r, state_nxt;
  logic [CW-1:0]            wr_cnt_r, wr_cnt_nxt;
  logic [CW-1:0]            rd_cnt_r, rd_cnt_nxt;
  logic [CW-1:0]            scan_addr_r, scan_addr_nxt;
  logic                     first_r, first_nxt;
  logic signed [DATA_W-1:0] min_r, min_nxt;
  logic signed [DATA_W-1:0] max_r, max_nxt;
  logic [CAP_W-1:0]         cap_r;

  logic                     out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]      out_status_r, out_status_nxt;
  logic signed [DATA_W-1:0] out_data_r, out_data_nxt;
  logic signed [DATA_W-1:0] out_min_r, out_min_nxt;
  logic signed [DATA_W-1:0] out_max_r, out_max_nxt;

  logic                     accept;
  logic [UW-1:0]            usable_cap;
  logic                     full;
  logic                     empty;
  logic                     scan_more;
  logic signed [DATA_W-1:0] cur_min, cur_max;

  assign accept = start && (state_r == S_IDLE);
  assign busy   = (state_r != S_IDLE);

  // Capacity saturates at the memory depth.
  assign usable_cap = (UW'(cap_r) > UW'(DEPTH)) ? UW'(DEPTH) : UW'(cap_r);
  assign full       = (UW'(wr_cnt_r) >= usable_cap);
  assign empty      = (rd_cnt_r >= wr_cnt_r);
  assign scan_more  = (scan_addr_r < wr_cnt_r);

  // Fold the word just read into the running extremes.
  always_comb begin
    if (first_r) begin
      cur_min = mem_rd_data;
      cur_max = mem_rd_data;
    end else begin
      cur_min = (mem_rd_data < min_r) ? mem_rd_data : min_r;
      cur_max = (mem_rd_data > max_r) ? mem_rd_data : max_r;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept && (in_req_type == REQ_DEQ) && !empty) begin
          state_nxt = S_DEQ;
        end else if (accept && (in_req_type == REQ_MINMAX) && !empty) begin
          state_nxt = S_SCAN;
        end
      end
      S_DEQ: begin
        state_nxt = S_IDLE;
      end
      S_SCAN: begin
        if (!scan_more) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Counters, memory control and results.
  always_comb begin
    wr_cnt_nxt     = wr_cnt_r;
    rd_cnt_nxt     = rd_cnt_r;
    scan_addr_nxt  = scan_addr_r;
    first_nxt      = first_r;
    min_nxt        = min_r;
    max_nxt        = max_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = ST_OK;
    out_data_nxt   = '0;
    out_min_nxt    = '0;
    out_max_nxt    = '0;
    mem_ctl        = '0;
    mem_wr_addr    = wr_cnt_r[AW-1:0];
    mem_rd_addr    = rd_cnt_r[AW-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (in_req_type)
            REQ_ENQ: begin
              out_valid_nxt = 1'b1;
              if (full) begin
                out_status_nxt = ST_OVERFLOW;
              end else begin
                mem_ctl.wr_en = 1'b1;
                wr_cnt_nxt    = wr_cnt_r + 1'b1;
              end
            end
            REQ_DEQ: begin
              if (empty) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = ST_UNDERFLOW;
                out_data_nxt   = -32'sd1;
              end else begin
                mem_ctl.rd_en = 1'b1;
              end
            end
            REQ_MINMAX: begin
              if (empty) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = ST_EMPTY;
              end else begin
                mem_ctl.rd_en = 1'b1;
                scan_addr_nxt = rd_cnt_r + 1'b1;
                first_nxt     = 1'b1;
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      S_DEQ: begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = mem_rd_data;
        rd_cnt_nxt    = rd_cnt_r + 1'b1;
      end
      S_SCAN: begin
        // One read is in flight every cycle; the last word lands when the
        // scan address has reached the write count.
        first_nxt = 1'b0;
        min_nxt   = cur_min;
        max_nxt   = cur_max;
        if (scan_more) begin
          mem_ctl.rd_en = 1'b1;
          mem_rd_addr   = scan_addr_r[AW-1:0];
          scan_addr_nxt = scan_addr_r + 1'b1;
        end else begin
          out_valid_nxt = 1'b1;
          out_min_nxt   = cur_min;
          out_max_nxt   = cur_max;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wr_cnt_r    <= '0;
      rd_cnt_r    <= '0;
      cap_r       <= CAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wr_cnt_r    <= wr_cnt_nxt;
      rd_cnt_r    <= rd_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    scan_addr_r  <= scan_addr_nxt;
    first_r      <= first_nxt;
    min_r        <= min_nxt;
    max_r        <= max_nxt;
    out_status_r <= out_status_nxt;
    out_data_r   <= out_data_nxt;
    out_min_r    <= out_min_nxt;
    out_max_r    <= out_max_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_data      = out_data_r;
  assign out_min_value = out_min_r;
  assign out_max_value = out_max_r;

endmodule

/* hw/rtl/linear_queue_min_max_core.sv */
// ----------------------------------------------------------------------------
// linear_queue_min_max_core
// Non-wrapping array queue of signed 32-bit values with a min/max scan.
// ----------------------------------------------------------------------------
// Usage:
//   Present in_req_type and in_value with start; the item is taken at a
//   clock edge where start is high and busy is low. Each item produces one
//   result, shown for a single cycle with out_valid on out_status, out_data,
//   out_min_value and out_max_value. The receiver cannot stall it.
//   Per request kind, from the accepting edge to out_valid:
//     enqueue, failed dequeue, failed query, unused code: result in the
//       next cycle, no busy, so these items may be issued every cycle;
//     dequeue: one memory read, busy until its data is returned;
//     query over N unread entries: busy while the scan runs, since
//       the scan reads one slot per cycle through the single read port.
//   The longest query is over a full queue of DEPTH entries.
//   cfg_we with cfg_wdata sets the capacity; write it only while idle.
//   Reset empties the queue and restores capacity 64; the slot memory is
//   not cleared, as only written slots are ever read.
// ----------------------------------------------------------------------------
module linear_queue_min_max_core #(
  parameter int DEPTH = lqmm_pkg::DEFAULT_DEPTH
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [lqmm_pkg::REQ_W-1:0]           in_req_type,
  input  logic signed [lqmm_pkg::DATA_W-1:0]   in_value,
  input  logic                                 cfg_we,
  input  logic [lqmm_pkg::CAP_W-1:0]           cfg_wdata,
  output logic                                 out_valid,
  output logic [lqmm_pkg::STATUS_W-1:0]        out_status,
  output logic signed [lqmm_pkg::DATA_W-1:0]   out_data,
  output logic signed [lqmm_pkg::DATA_W-1:0]   out_min_value,
  output logic signed [lqmm_pkg::DATA_W-1:0]   out_max_value
);
  import lqmm_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  mem_ctl_t                 mem_ctl;
  logic [AW-1:0]            mem_wr_addr;
  logic [AW-1:0]            mem_rd_addr;
  logic signed [DATA_W-1:0] mem_rd_data;

  lqmm_ctrl #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_req_type   (in_req_type),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .mem_ctl       (mem_ctl),
    .mem_wr_addr   (mem_wr_addr),
    .mem_rd_addr   (mem_rd_addr),
    .mem_rd_data   (mem_rd_data),
    .out_valid     (out_valid),
    .out_status    (out_status),
    .out_data      (out_data),
    .out_min_value (out_min_value),
    .out_max_value (out_max_value)
  );

  lqmm_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .ctl     (mem_ctl),
    .wr_addr (mem_wr_addr),
    .wr_data (in_value),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

endmodule

/* hw/rtl/lqmm_checker.sv */
// ----------------------------------------------------------------------------
// lqmm_checker
// Port-level checks on the queue core's results, bound to the top level.
// ----------------------------------------------------------------------------
module lqmm_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               start,
  input logic                               busy,
  input logic                               out_valid,
  input logic [lqmm_pkg::STATUS_W-1:0]      out_status,
  input logic signed [lqmm_pkg::DATA_W-1:0] out_data,
  input logic signed [lqmm_pkg::DATA_W-1:0] out_min_value,
  input logic signed [lqmm_pkg::DATA_W-1:0] out_max_value
);
  import lqmm_pkg::*;

  // Reset leaves the block idle with no result pending.
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && !busy))
    else $error("result or busy seen right after reset");

  // An underflow always carries data of minus one.
  a_underflow_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_UNDERFLOW)) |-> (out_data == -32'sd1))
    else $error("underflow result without data of minus one");

  // A failed request reports no extremes.
  a_fail_no_extremes: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != ST_OK)) |->
      ((out_min_value == '0) && (out_max_value == '0)))
    else $error("failed request reported min or max");

  // The smallest value never exceeds the largest.
  a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_min_value <= out_max_value))
    else $error("min value above max value");

  // An item taken while idle that gets no result next cycle keeps busy high.
  a_busy_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (out_valid || busy))
    else $error("accepted item neither answered nor holding busy");

endmodule

bind linear_queue_min_max_core lqmm_checker u_lqmm_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .start         (start),
  .busy          (busy),
  .out_valid     (out_valid),
  .out_status    (out_status),
  .out_data      (out_data),
  .out_min_value (out_min_value),
  .out_max_value (out_max_value)
);

/* verif/linear_queue_min_max_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_queue_min_max_core_tb
// Self-checking bench for the non-wrapping queue with min/max scan. A short
// directed run covers capacity corners and value extremes, then random
// phases mix enqueues, dequeues and queries under changing capacities while
// a scoreboard predicts every response and compares it field by field.
// ----------------------------------------------------------------------------
module linear_queue_min_max_core_tb;
  import lqmm_pkg::*;

  localparam int DEPTH          = DEFAULT_DEPTH;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int MAX_REPORTS    = 40;
  localparam int RANDOM_PHASES  = 12;
  localparam int PHASE_ITEMS    = 100;
  localparam logic [CAP_W-1:0] CAP_MAX = '1;

  typedef struct packed {
    status_t                  status;
    logic signed [DATA_W-1:0] data;
    logic signed [DATA_W-1:0] min_value;
    logic signed [DATA_W-1:0] max_value;
  } queue_resp_t;

  class lqmm_scoreboard;
    logic signed [DATA_W-1:0] slot_mem [DEPTH];
    int unsigned written_count;
    int unsigned read_count;
    int unsigned capacity;
    queue_resp_t awaited_responses [$];
    int error_count;

    function new();
      written_count = 0;
      read_count    = 0;
      capacity      = CAP_RESET;
      error_count   = 0;
    endfunction

    function void set_capacity(logic [CAP_W-1:0] cap);
      capacity = cap;
    endfunction

    function int unsigned pending();
      return awaited_responses.size();
    endfunction

    // Works out the response to one accepted request and queues it.
    function void take_request(req_t req, logic signed [DATA_W-1:0] value);
      queue_resp_t resp;
      int unsigned usable;
      int unsigned idx;
      logic signed [DATA_W-1:0] lo;
      logic signed [DATA_W-1:0] hi;
      resp = '0;
      usable = (capacity > DEPTH) ? DEPTH : capacity;
      case (req)
        REQ_ENQ: begin
          // Slots are never reused, so the queue stays full once it fills unless capacity is raised.
          if (written_count >= usable) begin
            resp.status = ST_OVERFLOW;
          end else begin
            slot_mem[written_count] = value;
            written_count++;
          end
        end
        REQ_DEQ: begin
          if (read_count >= written_count) begin
            resp.status = ST_UNDERFLOW;
            resp.data   = -1;
          end else begin
            resp.data = slot_mem[read_count];
            read_count++;
          end
        end
        REQ_MINMAX: begin
          if (read_count >= written_count) begin
            resp.status = ST_EMPTY;
          end else begin
            lo = slot_mem[read_count];
            hi = lo;
            for (idx = read_count + 1; idx < written_count; idx++) begin
              if (slot_mem[idx] < lo) lo = slot_mem[idx];
              if (slot_mem[idx] > hi) hi = slot_mem[idx];
            end
            resp.min_value = lo;
            resp.max_value = hi;
          end
        end
        default: ;
      endcase
      awaited_responses.push_back(resp);
    endfunction

    function void flag_field(string field, logic signed [DATA_W-1:0] want,
                             logic signed [DATA_W-1:0] got);
      error_count++;
      if (error_count <= MAX_REPORTS)
        $error("%s: expected %0d, got %0d", field, want, got);
    endfunction

    function void check_response(logic [STATUS_W-1:0] status,
                                  logic signed [DATA_W-1:0] data,
                                  logic signed [DATA_W-1:0] min_value,
                                  logic signed [DATA_W-1:0] max_value);
      queue_resp_t want;
      if (awaited_responses.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS)
          $error("response arrived with no request outstanding");
        return;
      end
      want = awaited_responses.pop_front();
      if (status !== want.status)
        flag_field("status", DATA_W'(want.status), DATA_W'(status));
      if (data !== want.data) flag_field("data", want.data, data);
      if (min_value !== want.min_value) flag_field("min_value", want.min_value, min_value);
      if (max_value !== want.max_value) flag_field("max_value", want.max_value, max_value);
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst_n;
  logic                     start;
  logic                     busy;
  logic [REQ_W-1:0]         in_req_type;
  logic signed [DATA_W-1:0] in_value;
  logic                     cfg_we;
  logic [CAP_W-1:0]         cfg_wdata;
  logic                     out_valid;
  logic [STATUS_W-1:0]      out_status;
  logic signed [DATA_W-1:0] out_data;
  logic signed [DATA_W-1:0] out_min_value;
  logic signed [DATA_W-1:0] out_max_value;

  lqmm_scoreboard queue_board;
  int idle_cycles = 0;

  always #10 clk = ~clk;

  linear_queue_min_max_core #(
    .DEPTH(DEPTH)
  ) i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_req_type  (in_req_type),
    .in_value     (in_value),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .out_valid    (out_valid),
    .out_status   (out_status),
    .out_data     (out_data),
    .out_min_value(out_min_value),
    .out_max_value(out_max_value)
  );

  // A response seen at this edge belongs to an earlier item, so it is
  // checked before the item accepted at the same edge is predicted.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid)
        queue_board.check_response(out_status, out_data, out_min_value, out_max_value);
      if (start && !busy)
        queue_board.take_request(req_t'(in_req_type), in_value);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  task automatic send_item(req_t req, logic signed [DATA_W-1:0] value);
    start       <= 1'b1;
    in_req_type <= req;
    in_value    <= value;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic pause_cycles(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (queue_board.pending() != 0 || busy) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_capacity(logic [CAP_W-1:0] cap);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= cap;
    @(posedge clk);
    cfg_we <= 1'b0;
    queue_board.set_capacity(cap);
  endtask

  // Mostly wide random values, with the two extremes and small ones to force ties.
  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7FFF_FFFF;
      2, 3:    return $signed($urandom_range(0, 8)) - 4;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int phase;
    int n;
    int burst_left;
    int deq_weight;
    int unsigned roll;
    int unsigned grown;
    logic [CAP_W-1:0] cap;
    req_t req;

    queue_board = new();
    rst_n       <= 1'b0;
    start       <= 1'b0;
    in_req_type <= REQ_NONE;
    in_value    <= '0;
    cfg_we      <= 1'b0;
    cfg_wdata   <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // With no capacity every enqueue, dequeue and query is refused or empty.
    write_capacity('0);
    send_item(REQ_ENQ, 5);
    send_item(REQ_DEQ, 0);
    send_item(REQ_MINMAX, 0);
    send_item(REQ_NONE, 0);

    write_capacity(7'd1);
    send_item(REQ_ENQ, 32'sh7FFF_FFFF);
    send_item(REQ_ENQ, 7);
    send_item(REQ_MINMAX, 0);
    send_item(REQ_DEQ, 0);
    send_item(REQ_DEQ, 0);
    send_item(REQ_MINMAX, 0);

    // Capacity above the array size saturates at the array size.
    write_capacity(CAP_MAX);
    send_item(REQ_ENQ, 32'sh8000_0000);
    send_item(REQ_ENQ, -1);
    send_item(REQ_ENQ, 0);
    send_item(REQ_ENQ, 1);
    send_item(REQ_ENQ, 32'sh7FFF_FFFF);
    send_item(REQ_MINMAX, 0);
    send_item(REQ_DEQ, 0);
    send_item(REQ_MINMAX, 0);
    send_item(REQ_NONE, -1);

    // Lowering capacity below the slots already written makes the queue full.
    write_capacity(7'd3);
    send_item(REQ_ENQ, 9);
    send_item(REQ_MINMAX, 0);
    send_item(REQ_DEQ, 0);

    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      if (phase == RANDOM_PHASES - 1) begin
        cap = CAP_W'(DEPTH);
      end else if ($urandom_range(0, 4) == 0) begin
        cap = CAP_W'($urandom_range(0, CAP_MAX));
      end else begin
        grown = queue_board.written_count + $urandom_range(1, 8);
        cap = (grown > CAP_MAX) ? CAP_MAX : CAP_W'(grown);
      end
      write_capacity(cap);
      // Odd phases dequeue rarely so that unread entries pile up for long scans.
      deq_weight = (phase % 2 == 0) ? 25 : 5;
      burst_left = $urandom_range(1, 30);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        roll = $urandom_range(0, 99);
        if (roll < 40) req = REQ_ENQ;
        else if (roll < 40 + deq_weight) req = REQ_DEQ;
        else if (roll < 96) req = REQ_MINMAX;
        else req = REQ_NONE;
        send_item(req, pick_value());
        if ($urandom_range(0, 39) == 0) begin
          wait_drained();
        end else if (phase % 4 != 3) begin
          burst_left--;
          if (burst_left == 0) begin
            pause_cycles($urandom_range(1, 8));
            burst_left = $urandom_range(1, 30);
          end
        end
      end
    end

    wait_drained();
    repeat (DEPTH + 4) @(posedge clk);
    if (queue_board.error_count == 0 && queue_board.pending() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

/* files.f */
hw/rtl/lqmm_pkg.sv
hw/rtl/lqmm_mem.sv
hw/rtl/lqmm_ctrl.sv
hw/rtl/linear_queue_min_max_core.sv
hw/rtl/lqmm_checker.sv
verif/linear_queue_min_max_core_tb.sv
